// File: design/bsdc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsdc_pkg
// Shared types and constants for the buffered setpoint drive controller.
// ----------------------------------------------------------------------------
package bsdc_pkg;

   // Commands carried by an input item
   typedef enum logic [1:0] {
      CMD_PUSH  = 2'd0,
      CMD_TICK  = 2'd1,
      CMD_APPLY = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   // Output modes
   localparam logic [1:0] MODE_NONE    = 2'd0;
   localparam logic [1:0] MODE_MOD     = 2'd1;
   localparam logic [1:0] MODE_VOLTAGE = 2'd2;
   localparam logic [1:0] MODE_CURRENT = 2'd3;

   // Bridge channel modes
   localparam logic [1:0] CH_NORMAL   = 2'd0;
   localparam logic [1:0] CH_INVERTED = 2'd1;
   localparam logic [1:0] CH_INACTIVE = 2'd2;
   localparam logic [1:0] CH_OFF      = 2'd3;

   // Register map
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 31;
   localparam logic [CSR_IDX_W-1:0] REG_OUTPUT_MODE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PWM_BIPOLAR  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_DUTY     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_TIMER_PERIOD = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_INTERP_STEPS = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_FILTER_CONST = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_PROP    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_INTEG   = 3'd7;

   // Register reset values
   localparam logic [15:0] MAX_DUTY_RST     = 16'd31130;
   localparam logic [15:0] TIMER_PERIOD_RST = 16'd4200;
   localparam logic [16:0] FILTER_CONST_RST = 17'd6554;

   // Divider widths
   localparam int DIV_NUM_W = 48;
   localparam int DIV_DEN_W = 31;

   typedef struct packed {
      logic [1:0]          command;
      logic signed [31:0]  sample_value;
      logic signed [31:0]  current_a;
      logic signed [31:0]  current_b;
      logic [30:0]         supply_volts;
      logic                fault_active;
   } req_type;

   typedef struct packed {
      logic [15:0]         duty;
      logic [1:0]          chan_one_mode;
      logic [1:0]          chan_three_mode;
      logic                is_running;
      logic signed [15:0]  modulation_now;
      logic signed [31:0]  filtered_current;
      logic [9:0]          ring_fill;
      logic                push_dropped;
   } rsp_type;

   // Classified item passed from front to back
   typedef struct packed {
      cmd_type op;
      req_type req;
   } job_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quo;
      logic                 rem_nz;
   } div_rsp_type;

   typedef enum logic [4:0] {
      S_IDLE, S_DISPATCH, S_LP_MUL, S_LP_ADD, S_POP, S_INT_MUL, S_INT_START,
      S_INT_DIV, S_DELIVER, S_RATIO, S_RATIO_DIV, S_PI_ERR, S_PI_MP, S_PI_MI,
      S_PI_SUM, S_APPLY, S_DUTY, S_RESP
   } back_state_type;

   // Saturate to 32-bit signed
   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = 64'sh0000_0000_7FFF_FFFF;
      lo = -64'sh0000_0000_8000_0000;
      if (x > hi) begin
         return 32'sh7FFF_FFFF;
      end else if (x < lo) begin
         return 32'sh8000_0000;
      end
      return x[31:0];
   endfunction

endpackage
`default_nettype wire

// File: design/bsdc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsdc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bsdc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// File: design/bsdc_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsdc_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bsdc_div
   import bsdc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type div_req,
   output div_rsp_type      div_rsp
);

   localparam int CNT_W = $clog2(DIV_NUM_W + 1);

   logic [DIV_NUM_W-1:0] num_ff, num_in;
   logic [DIV_DEN_W:0]   rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic [DIV_DEN_W:0]   rem_sh;
   logic [DIV_DEN_W+1:0] diff;

   // Shift in one numerator bit and try a subtract
   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff[DIV_DEN_W-1:0], num_ff[DIV_NUM_W-1]};
      diff    = {1'b0, rem_sh} - {2'b00, den_ff};
      if (div_req.start) begin
         num_in  = div_req.num;
         den_in  = div_req.den;
         rem_in  = '0;
         cnt_in  = CNT_W'(DIV_NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[DIV_DEN_W+1]) begin
            rem_in = diff[DIV_DEN_W:0];
            num_in = {num_ff[DIV_NUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            num_in = {num_ff[DIV_NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign div_rsp.done   = done_ff;
   assign div_rsp.quo    = num_ff;
   assign div_rsp.rem_nz = |rem_ff;

`ifndef SYNTH
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider finished without running");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !busy_ff)
      else $error("divider restarted while busy");
   a_cnt_zero_idle: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> cnt_ff == '0 || $past(div_req.start) == 1'b0)
      else $error("divider count out of step");
`endif

endmodule
`default_nettype wire

// File: design/bsdc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsdc_front
// Accepts items, classifies the command and queues them for the back end.
// ----------------------------------------------------------------------------
module bsdc_front
   import bsdc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         job_valid,
   input  wire logic    job_ready,
   output job_type      job
);

   job_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign req_ready = (cnt_ff != 2'd2);
   assign job_valid = (cnt_ff != 2'd0);
   assign job       = q_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = job_valid && job_ready;

   // Advance queue pointers and count
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      // Store the classified item
      if (push) begin
         q_ff[wr_ptr_ff].op  <= cmd_type'(req_data.command);
         q_ff[wr_ptr_ff].req <= req_data;
      end
   end

`ifndef SYNTH
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("queue count overflow");
   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0 || cnt_ff == 2'd2) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers out of step");
   a_one_ptr: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd1 |-> wr_ptr_ff != rd_ptr_ff)
      else $error("queue pointers out of step");
`endif

endmodule
`default_nettype wire

// File: design/bsdc_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsdc_back
// Executes queued items: ring, filter, playback, PI loop, duty and status.
// ----------------------------------------------------------------------------
module bsdc_back
   import bsdc_pkg::*;
#(
   parameter int RING_DEPTH = 1024
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  job_valid,
   output logic                       job_ready,
   input  wire job_type               job,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_data
);

   localparam int PTR_W = $clog2(RING_DEPTH);
   localparam int FW    = (PTR_W + 1 > 10) ? PTR_W + 1 : 10;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   // Configuration
   logic [1:0]  mode_ff, mode_in;
   logic        bipolar_ff, bipolar_in;
   logic [15:0] max_duty_ff, max_duty_in;
   logic [15:0] period_ff, period_in;
   logic [7:0]  steps_ff, steps_in;
   logic [16:0] fc_ff, fc_in;
   logic [30:0] gp_ff, gp_in;
   logic [30:0] gi_ff, gi_in;

   // Control and architectural state
   back_state_type     state_ff, state_in;
   job_type            item_ff, item_in;
   logic [PTR_W-1:0]   rp_ff, rp_in, wp_ff, wp_in;
   logic [7:0]         icnt_ff, icnt_in;
   logic signed [31:0] prev_ff, prev_in, next_ff, next_in;
   logic               empty_ff, empty_in;
   logic signed [31:0] lp_ff, lp_in, target_ff, target_in;
   logic signed [31:0] integ_ff, integ_in, osample_ff, osample_in;
   logic               running_ff, running_in;
   logic signed [15:0] mod_ff, mod_in;
   logic [15:0]        duty_ff, duty_in;
   logic [1:0]         ch1_ff, ch1_in, ch3_ff, ch3_in;
   logic               dropped_ff, dropped_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   // Datapath scratch registers
   logic signed [50:0] prod_ff, prod_in;
   logic [8:0]         c_ff, c_in;
   logic signed [42:0] d_ff, d_in;
   logic signed [31:0] num_ff, num_in;
   logic signed [31:0] err_ff, err_in;
   logic signed [63:0] p1_ff, p1_in, p2_ff, p2_in;
   logic signed [48:0] m_ff, m_in;

   // Ring memory and divider
   logic               ram_we, ram_re;
   logic [PTR_W-1:0]   ram_waddr;
   logic [31:0]        ram_wdata, ram_rdata;
   div_req_type        div_req;
   div_rsp_type        div_rsp;

   // Combinational helpers
   logic signed [32:0] c1w, c1_abs, c2_abs, diff33, dlt33;
   logic signed [31:0] c1, cur;
   logic signed [50:0] lp_sum;
   logic signed [63:0] lp_new, v64, in64, vin64;
   logic [8:0]         cnext;
   logic [PTR_W-1:0]   wp_nxt;
   logic [31:0]        nmag;
   logic [42:0]        dmag;
   logic signed [48:0] qs, lim49;
   logic [15:0]        lim;
   logic [16:0]        bip;
   logic [14:0]        umag;
   logic [32:0]        bprod;
   logic [30:0]        uprod;
   logic [PTR_W:0]     fill_w;
   logic [FW-1:0]      fill_x;
   logic               is_tick;

   assign job_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign is_tick   = (item_ff.op == CMD_TICK);

   always_comb begin
      // Hold by default
      mode_in     = mode_ff;     bipolar_in  = bipolar_ff;
      max_duty_in = max_duty_ff; period_in   = period_ff;
      steps_in    = steps_ff;    fc_in       = fc_ff;
      gp_in       = gp_ff;       gi_in       = gi_ff;
      state_in    = state_ff;    item_in     = item_ff;
      rp_in       = rp_ff;       wp_in       = wp_ff;
      icnt_in     = icnt_ff;     prev_in     = prev_ff;
      next_in     = next_ff;     empty_in    = empty_ff;
      lp_in       = lp_ff;       target_in   = target_ff;
      integ_in    = integ_ff;    osample_in  = osample_ff;
      running_in  = running_ff;  mod_in      = mod_ff;
      duty_in     = duty_ff;     ch1_in      = ch1_ff;
      ch3_in      = ch3_ff;      dropped_in  = dropped_ff;
      prod_in     = prod_ff;     c_in        = c_ff;
      d_in        = d_ff;        num_in      = num_ff;
      err_in      = err_ff;      p1_in       = p1_ff;
      p2_in       = p2_ff;       m_in        = m_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      ram_we    = 1'b0;
      ram_waddr = wp_ff;
      ram_wdata = item_ff.req.sample_value;
      ram_re    = 1'b0;
      div_req.start = 1'b0;
      div_req.num   = '0;
      div_req.den   = '0;

      // Current selection: negated second phase against the first
      c1w    = -$signed({item_ff.req.current_b[31], item_ff.req.current_b});
      c1     = (c1w > 33'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF : c1w[31:0];
      c1_abs = (c1 < 0) ? -$signed({c1[31], c1}) : $signed({c1[31], c1});
      c2_abs = (item_ff.req.current_a < 0) ?
               -$signed({item_ff.req.current_a[31], item_ff.req.current_a}) :
               $signed({item_ff.req.current_a[31], item_ff.req.current_a});
      cur    = (c1_abs > c2_abs) ? c1 : item_ff.req.current_a;
      diff33 = $signed({cur[31], cur}) - $signed({lp_ff[31], lp_ff});
      lp_sum = prod_ff + 51'sd32768;
      lp_new = $signed({{32{lp_ff[31]}}, lp_ff})
             + $signed({{29{lp_sum[50]}}, lp_sum[50:16]});
      cnext  = {1'b0, icnt_ff} + 9'd1;
      dlt33  = $signed({next_ff[31], next_ff}) - $signed({prev_ff[31], prev_ff});
      dmag   = d_ff[42] ? 43'(-d_ff) : 43'(d_ff);
      nmag   = num_ff[31] ? 32'(-$signed({num_ff[31], num_ff})) : 32'(num_ff);
      wp_nxt = ptr_inc(wp_ff);
      qs     = $signed({1'b0, div_rsp.quo});
      v64    = $signed({{32{integ_ff[31]}}, integ_ff})
             + $signed({{16{p1_ff[63]}}, p1_ff[63:16]});
      in64   = $signed({{32{integ_ff[31]}}, integ_ff})
             + $signed({{16{p2_ff[63]}}, p2_ff[63:16]});
      vin64  = $signed({33'd0, item_ff.req.supply_volts});
      lim    = (max_duty_ff > 16'd32767) ? 16'd32767 : max_duty_ff;
      lim49  = $signed({33'd0, lim});
      bip    = 17'($signed({mod_ff[15], mod_ff}) + 17'sd32768);
      umag   = mod_ff[15] ? 15'(-mod_ff) : mod_ff[14:0];
      bprod  = period_ff * bip;
      uprod  = period_ff * umag;

      unique case (state_ff)
         S_IDLE: begin
            if (job_valid) begin
               item_in  = job;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            dropped_in = 1'b0;
            unique case (item_ff.op)
               CMD_PUSH: begin
                  // Drop a push into a full ring
                  if (wp_nxt == rp_ff) begin
                     dropped_in = 1'b1;
                  end else begin
                     ram_we = 1'b1;
                     wp_in  = wp_nxt;
                  end
                  state_in = S_RESP;
               end
               CMD_TICK: begin
                  state_in = S_LP_MUL;
               end
               CMD_APPLY: begin
                  osample_in = item_ff.req.sample_value;
                  state_in   = S_DELIVER;
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end
         S_LP_MUL: begin
            prod_in  = diff33 * $signed({1'b0, fc_ff});
            state_in = S_LP_ADD;
         end
         S_LP_ADD: begin
            lp_in = sat32(lp_new);
            c_in  = cnext;
            if (cnext > {1'b0, steps_ff}) begin
               icnt_in = '0;
               if (rp_ff != wp_ff) begin
                  ram_re   = 1'b1;
                  state_in = S_POP;
               end else begin
                  // Ring ran dry: stop the bridge
                  if (!empty_ff) begin
                     running_in = 1'b0;
                     rp_in      = '0;
                     wp_in      = '0;
                     ch1_in     = CH_OFF;
                     ch3_in     = CH_OFF;
                  end
                  empty_in = 1'b1;
                  state_in = S_DELIVER;
               end
            end else begin
               icnt_in  = cnext[7:0];
               state_in = empty_ff ? S_DELIVER : S_INT_MUL;
            end
         end
         S_POP: begin
            prev_in    = next_ff;
            next_in    = ram_rdata;
            rp_in      = ptr_inc(rp_ff);
            osample_in = next_ff;
            running_in = 1'b1;
            empty_in   = 1'b0;
            state_in   = S_DELIVER;
         end
         S_INT_MUL: begin
            d_in     = dlt33 * $signed({1'b0, c_ff});
            state_in = S_INT_START;
         end
         S_INT_START: begin
            div_req.start = 1'b1;
            div_req.num   = DIV_NUM_W'(dmag);
            div_req.den   = DIV_DEN_W'({1'b0, steps_ff} + 9'd1);
            state_in      = S_INT_DIV;
         end
         S_INT_DIV: begin
            // Floor division: step down on a negative inexact quotient
            if (div_rsp.done) begin
               if (d_ff[42]) begin
                  qs = -qs - $signed({48'd0, div_rsp.rem_nz});
               end
               osample_in = prev_ff + qs[31:0];
               running_in = 1'b1;
               state_in   = S_DELIVER;
            end
         end
         S_DELIVER: begin
            if (is_tick && !running_ff) begin
               state_in = S_RESP;
            end else begin
               unique case (mode_ff)
                  MODE_MOD: begin
                     m_in     = $signed({{18{osample_ff[31]}}, osample_ff[31:1]});
                     state_in = S_APPLY;
                  end
                  MODE_VOLTAGE: begin
                     num_in   = osample_ff;
                     state_in = S_RATIO;
                  end
                  MODE_CURRENT: begin
                     target_in  = osample_ff;
                     running_in = 1'b1;
                     state_in   = is_tick ? S_PI_ERR : S_RESP;
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_RATIO: begin
            if (item_ff.req.supply_volts == '0) begin
               // Zero supply saturates to the sign of the numerator
               if (num_ff > 0) begin
                  m_in = 49'sh0_7FFF_FFFF;
               end else if (num_ff < 0) begin
                  m_in = -49'sh0_8000_0000;
               end else begin
                  m_in = '0;
               end
               state_in = S_APPLY;
            end else begin
               div_req.start = 1'b1;
               div_req.num   = {1'b0, nmag, 15'd0};
               div_req.den   = item_ff.req.supply_volts;
               state_in      = S_RATIO_DIV;
            end
         end
         S_RATIO_DIV: begin
            if (div_rsp.done) begin
               m_in     = num_ff[31] ? -qs : qs;
               state_in = S_APPLY;
            end
         end
         S_PI_ERR: begin
            err_in   = sat32($signed({{32{target_ff[31]}}, target_ff})
                             - $signed({{32{lp_ff[31]}}, lp_ff}));
            state_in = S_PI_MP;
         end
         S_PI_MP: begin
            p1_in    = 64'(err_ff * $signed({1'b0, gp_ff}));
            state_in = S_PI_MI;
         end
         S_PI_MI: begin
            p2_in    = 64'(err_ff * $signed({1'b0, gi_ff}));
            state_in = S_PI_SUM;
         end
         S_PI_SUM: begin
            num_in = sat32(v64);
            if (in64 > vin64) begin
               integ_in = vin64[31:0];
            end else if (in64 < -vin64) begin
               integ_in = 32'(-vin64);
            end else begin
               integ_in = in64[31:0];
            end
            state_in = S_RATIO;
         end
         S_APPLY: begin
            // Clamp and hold the modulation
            if (m_ff > lim49) begin
               mod_in = $signed(lim);
            end else if (m_ff < -lim49) begin
               mod_in = 16'(-lim49);
            end else begin
               mod_in = m_ff[15:0];
            end
            state_in = (mode_ff != MODE_NONE && !item_ff.req.fault_active) ?
                       S_DUTY : S_RESP;
         end
         S_DUTY: begin
            if (bipolar_ff) begin
               duty_in = bprod[31:16];
               ch1_in  = CH_NORMAL;
               ch3_in  = CH_INVERTED;
            end else begin
               duty_in = uprod[30:15];
               ch1_in  = mod_ff[15] ? CH_INACTIVE : CH_NORMAL;
               ch3_in  = mod_ff[15] ? CH_NORMAL : CH_INACTIVE;
            end
            running_in = 1'b1;
            state_in   = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Status snapshot
      fill_w = (wp_ff >= rp_ff) ? ({1'b0, wp_ff} - {1'b0, rp_ff}) :
               ({1'b0, wp_ff} + (PTR_W + 1)'(RING_DEPTH) - {1'b0, rp_ff});
      fill_x = FW'(fill_w);
      if (state_ff == S_RESP && (!rsp_valid_ff || rsp_ready)) begin
         rsp_in.duty             = duty_ff;
         rsp_in.chan_one_mode    = ch1_ff;
         rsp_in.chan_three_mode  = ch3_ff;
         rsp_in.is_running       = running_ff;
         rsp_in.modulation_now   = mod_ff;
         rsp_in.filtered_current = lp_ff;
         rsp_in.ring_fill        = fill_x[9:0];
         rsp_in.push_dropped     = dropped_ff;
      end else if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // Register writes
      if (csr_we) begin
         case (csr_index)
            REG_OUTPUT_MODE: begin
               mode_in = csr_wdata[1:0];
               if (csr_wdata[1:0] == MODE_NONE) begin
                  running_in = 1'b0;
                  rp_in      = '0;
                  wp_in      = '0;
                  ch1_in     = CH_OFF;
                  ch3_in     = CH_OFF;
               end
            end
            REG_PWM_BIPOLAR:  bipolar_in  = csr_wdata[0];
            REG_MAX_DUTY:     max_duty_in = csr_wdata[15:0];
            REG_TIMER_PERIOD: period_in   = csr_wdata[15:0];
            REG_INTERP_STEPS: steps_in    = csr_wdata[7:0];
            REG_FILTER_CONST: fc_in       = csr_wdata[16:0];
            REG_GAIN_PROP:    gp_in       = csr_wdata[30:0];
            REG_GAIN_INTEG:   gi_in       = csr_wdata[30:0];
            default: begin
               mode_in = mode_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= MODE_NONE;
         bipolar_ff   <= 1'b0;
         max_duty_ff  <= MAX_DUTY_RST;
         period_ff    <= TIMER_PERIOD_RST;
         steps_ff     <= '0;
         fc_ff        <= FILTER_CONST_RST;
         gp_ff        <= '0;
         gi_ff        <= '0;
         rp_ff        <= '0;
         wp_ff        <= '0;
         icnt_ff      <= '0;
         prev_ff      <= '0;
         next_ff      <= '0;
         empty_ff     <= 1'b1;
         lp_ff        <= '0;
         target_ff    <= '0;
         integ_ff     <= '0;
         osample_ff   <= '0;
         running_ff   <= 1'b0;
         mod_ff       <= '0;
         duty_ff      <= '0;
         ch1_ff       <= CH_OFF;
         ch3_ff       <= CH_OFF;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         bipolar_ff   <= bipolar_in;
         max_duty_ff  <= max_duty_in;
         period_ff    <= period_in;
         steps_ff     <= steps_in;
         fc_ff        <= fc_in;
         gp_ff        <= gp_in;
         gi_ff        <= gi_in;
         rp_ff        <= rp_in;
         wp_ff        <= wp_in;
         icnt_ff      <= icnt_in;
         prev_ff      <= prev_in;
         next_ff      <= next_in;
         empty_ff     <= empty_in;
         lp_ff        <= lp_in;
         target_ff    <= target_in;
         integ_ff     <= integ_in;
         osample_ff   <= osample_in;
         running_ff   <= running_in;
         mod_ff       <= mod_in;
         duty_ff      <= duty_in;
         ch1_ff       <= ch1_in;
         ch3_ff       <= ch3_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
      prod_ff <= prod_in;
      c_ff    <= c_in;
      d_ff    <= d_in;
      num_ff  <= num_in;
      err_ff  <= err_in;
      p1_ff   <= p1_in;
      p2_ff   <= p2_in;
      m_ff    <= m_in;
   end

   bsdc_ram #(
      .WIDTH (32),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (rp_ff),
      .rd_data (ram_rdata)
   );

   bsdc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

`ifndef SYNTH
   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_INT_DIV || state_ff == S_RATIO_DIV))
      else $error("divider result with no consumer");
   a_halt_cfg: assert property (@(posedge clock) disable iff (reset)
      (csr_we && csr_index == REG_OUTPUT_MODE && csr_wdata[1:0] == MODE_NONE)
      |=> (!running_ff && rp_ff == '0 && wp_ff == '0))
      else $error("mode none did not stop the bridge");
   a_duty_runs: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DUTY |=> running_ff)
      else $error("duty update left bridge stopped");
`endif

endmodule
`default_nettype wire

// File: design/buffered_setpoint_drive_controller_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Flow: a push or idle command goes from dispatch straight to the response;
// a PWM tick also runs the filter and playback steps, plus a divide for each
// interpolation or supply ratio, each on the 48-step serial divider. The back
// end takes one item at a time; a two-item queue keeps accepting until full.
// Reset: synchronous; registers to defaults, ring empty, both channels off.
// ----------------------------------------------------------------------------
// buffered_setpoint_drive_controller_core
// H-bridge setpoint drive: ring playback, current filter, PI loop and duty.
// ----------------------------------------------------------------------------
module buffered_setpoint_drive_controller_core
   import bsdc_pkg::*;
#(
   parameter int RING_DEPTH = 1024
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   logic    job_valid;
   logic    job_ready;
   job_type job;

   bsdc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .job_valid (job_valid),
      .job_ready (job_ready),
      .job       (job)
   );

   bsdc_back #(
      .RING_DEPTH (RING_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job_ready (job_ready),
      .job       (job),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire
